// ===== src/iso_date_check_and_weekday_defines.svh =====
// Assertion macros for the checker file iso_dc_chk.sv.
`ifndef ISO_DATE_CHECK_AND_WEEKDAY_DEFINES_SVH
`define ISO_DATE_CHECK_AND_WEEKDAY_DEFINES_SVH

// Property checked only while out of reset.
`define ISO_DC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ISO_DC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/iso_dc_pkg.sv =====
`timescale 1ns / 1ps

package iso_dc_pkg;

    // result status codes
    localparam logic [1:0] ST_VALID  = 2'd0;
    localparam logic [1:0] ST_LENGTH = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;
    localparam logic [1:0] ST_DATE   = 2'd3;

    // character positions in yyyy-mm-dd
    localparam logic [3:0] POS_DASH_1  = 4'd4;
    localparam logic [3:0] POS_DASH_2  = 4'd7;
    localparam logic [3:0] POS_LAST    = 4'd9;
    localparam logic [3:0] POS_END     = 4'd10;
    localparam logic [3:0] POS_MAX     = 4'd15;
    localparam logic [7:0] CHAR_DASH   = 8'h2d;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // reciprocals: floor(x*RECIP_100 >> RECIP_100_SH) = x/100 for x < 16384,
    // floor(x*RECIP_7 >> RECIP_7_SH) = x/7 for x < 32768
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [16:0] RECIP_7      = 17'd74899;
    localparam int          RECIP_7_SH   = 19;

    typedef struct packed {
        logic        len_ok;
        logic        fmt_ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
    } t_date_rec;

    // floor(23*m/9) for months 1..12
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] t;
        unique case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd17;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd30;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    // days of a month in a common year
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] t;
        unique case (m)
            4'd2:                      t = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   t = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        t = 5'd31;
            default:                   t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== src/iso_dc_if.sv =====
`timescale 1ns / 1ps

interface iso_dc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface iso_dc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] weekday;

    modport source (output valid, output status, output weekday, input ready);
    modport sink   (input valid, input status, input weekday, output ready);
endinterface

// ===== src/iso_dc_fifo.sv =====
`timescale 1ns / 1ps

module iso_dc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  iso_dc_pkg::t_date_rec i_push_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output iso_dc_pkg::t_date_rec o_data
);

    iso_dc_pkg::t_date_rec                r_mem [iso_dc_pkg::QUEUE_DEPTH];
    logic [iso_dc_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [iso_dc_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [iso_dc_pkg::QUEUE_CNT_W-1:0]   r_count;
    logic                                 do_push;
    logic                                 do_pop;

    assign o_full  = (r_count == iso_dc_pkg::QUEUE_CNT_W'(iso_dc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == iso_dc_pkg::QUEUE_PTR_W'(iso_dc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == iso_dc_pkg::QUEUE_PTR_W'(iso_dc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/iso_dc_front.sv =====
`timescale 1ns / 1ps

module iso_dc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_char_code,
    input  logic                  i_end_of_string,
    output logic                  o_push,
    output iso_dc_pkg::t_date_rec o_rec
);

    logic [3:0]  r_pos;
    logic [13:0] r_year;
    logic [6:0]  r_month;
    logic [6:0]  r_day;
    logic        r_fmt;

    logic [3:0]  n_pos;
    logic [13:0] n_year;
    logic [6:0]  n_month;
    logic [6:0]  n_day;
    logic        n_fmt;
    logic        is_digit;
    logic [3:0]  digit;

    assign is_digit = (i_char_code >= iso_dc_pkg::CHAR_ZERO)
                   && (i_char_code <= iso_dc_pkg::CHAR_NINE);
    assign digit    = is_digit ? i_char_code[3:0] : 4'd0;

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_fmt   = r_fmt;
        n_pos   = (r_pos < iso_dc_pkg::POS_MAX) ? r_pos + 4'd1 : r_pos;
        if (r_pos < iso_dc_pkg::POS_END) begin
            priority if (r_pos == iso_dc_pkg::POS_DASH_1 || r_pos == iso_dc_pkg::POS_DASH_2) begin
                if (i_char_code != iso_dc_pkg::CHAR_DASH) begin
                    n_fmt = 1'b0;
                end
            end else if (!is_digit) begin
                n_fmt = 1'b0;
            end else if (r_pos < iso_dc_pkg::POS_DASH_1) begin
                n_year = 14'(r_year * 14'd10 + 14'(digit));
            end else if (r_pos < iso_dc_pkg::POS_DASH_2) begin
                n_month = 7'(r_month * 7'd10 + 7'(digit));
            end else begin
                n_day = 7'(r_day * 7'd10 + 7'(digit));
            end
        end
    end

    // the last beat sees its own digit already folded in
    assign o_push       = i_accept && i_end_of_string;
    assign o_rec.len_ok = (r_pos == iso_dc_pkg::POS_LAST);
    assign o_rec.fmt_ok = n_fmt;
    assign o_rec.year   = n_year;
    assign o_rec.month  = n_month;
    assign o_rec.day    = n_day;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_fmt   <= 1'b1;
        end else if (i_accept) begin
            if (i_end_of_string) begin
                r_pos   <= '0;
                r_year  <= '0;
                r_month <= '0;
                r_day   <= '0;
                r_fmt   <= 1'b1;
            end else begin
                r_pos   <= n_pos;
                r_year  <= n_year;
                r_month <= n_month;
                r_day   <= n_day;
                r_fmt   <= n_fmt;
            end
        end
    end

endmodule

// ===== src/iso_dc_back.sv =====
`timescale 1ns / 1ps

module iso_dc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  iso_dc_pkg::t_date_rec i_rec,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic [2:0]            o_weekday
);

    logic en;

    // stage 1: quotients by 100 and 400, shifted year for Jan/Feb, day-plus-year term
    logic                  r_s1_v;
    iso_dc_pkg::t_date_rec r_s1_rec;
    logic [7:0]            r_s1_q100;
    logic [5:0]            r_s1_q400;
    logic [13:0]           r_s1_ya;
    logic [14:0]           r_s1_da;
    logic [7:0]            r_s1_qa100;
    logic [5:0]            r_s1_qa400;

    logic [26:0] p_q100;
    logic [24:0] p_q400;
    logic [13:0] ya;
    logic [14:0] da;
    logic [26:0] p_qa100;
    logic [24:0] p_qa400;

    // stage 2: status and weekday sum
    logic        r_s2_v;
    logic [1:0]  r_s2_status;
    logic [14:0] r_s2_sum;

    logic        leap;
    logic        month_ok;
    logic [4:0]  limit;
    logic [1:0]  status;
    logic [14:0] sum;

    // output stage: sum mod 7
    logic [31:0] p_q7;
    logic [12:0] q7;
    logic [15:0] q7x7;
    logic [15:0] rem;

    logic        r_out_v;
    logic [1:0]  r_out_status;
    logic [2:0]  r_out_weekday;

    assign en    = !r_out_v || i_ready;
    assign o_pop = en && i_valid;

    assign p_q100  = 27'(i_rec.year) * 27'(iso_dc_pkg::RECIP_100);
    assign p_q400  = 25'(i_rec.year[13:2]) * 25'(iso_dc_pkg::RECIP_100);
    assign ya      = (i_rec.month < 7'd3) ? i_rec.year - 14'd1 : i_rec.year;
    assign da      = (i_rec.month < 7'd3) ? 15'(i_rec.day) + 15'(i_rec.year)
                                          : 15'(i_rec.day) + 15'(i_rec.year) - 15'd2;
    assign p_qa100 = 27'(ya) * 27'(iso_dc_pkg::RECIP_100);
    assign p_qa400 = 25'(ya[13:2]) * 25'(iso_dc_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_rec   <= i_rec;
            r_s1_q100  <= p_q100[iso_dc_pkg::RECIP_100_SH +: 8];
            r_s1_q400  <= p_q400[iso_dc_pkg::RECIP_100_SH +: 6];
            r_s1_ya    <= ya;
            r_s1_da    <= da;
            r_s1_qa100 <= p_qa100[iso_dc_pkg::RECIP_100_SH +: 8];
            r_s1_qa400 <= p_qa400[iso_dc_pkg::RECIP_100_SH +: 6];
        end
    end

    assign leap = (r_s1_rec.year[1:0] == 2'b00)
               && ((r_s1_rec.year != 14'(r_s1_q100 * 14'd100))
                   || (r_s1_rec.year == 14'(r_s1_q400 * 14'd400)));
    assign month_ok = (r_s1_rec.month >= 7'd1) && (r_s1_rec.month <= 7'd12);
    assign limit = month_ok
                 ? iso_dc_pkg::month_days(r_s1_rec.month[3:0])
                   + 5'((r_s1_rec.month == 7'd2) && leap)
                 : 5'd0;

    always_comb begin
        priority if (!r_s1_rec.len_ok) begin
            status = iso_dc_pkg::ST_LENGTH;
        end else if (!r_s1_rec.fmt_ok) begin
            status = iso_dc_pkg::ST_FORMAT;
        end else if (!month_ok || r_s1_rec.day < 7'd1 || r_s1_rec.day > 7'(limit)
                     || r_s1_rec.year == 14'd0) begin
            status = iso_dc_pkg::ST_DATE;
        end else begin
            status = iso_dc_pkg::ST_VALID;
        end
    end

    assign sum = 15'(month_ok ? iso_dc_pkg::month_term(r_s1_rec.month[3:0]) : 5'd0)
               + r_s1_da + 15'd4 + 15'(r_s1_ya[13:2])
               - 15'(r_s1_qa100) + 15'(r_s1_qa400);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_status <= status;
            r_s2_sum    <= sum;
        end
    end

    assign p_q7 = 32'(r_s2_sum) * 32'(iso_dc_pkg::RECIP_7);
    assign q7   = p_q7[iso_dc_pkg::RECIP_7_SH +: 13];
    assign q7x7 = {q7, 3'b000} - {3'b000, q7};
    assign rem  = 16'(r_s2_sum) - q7x7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_status  <= r_s2_status;
            r_out_weekday <= (r_s2_status == iso_dc_pkg::ST_VALID) ? rem[2:0] : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    assign o_valid   = r_out_v;
    assign o_status  = r_out_status;
    assign o_weekday = r_out_weekday;

endmodule

// ===== src/iso_date_check_and_weekday.sv =====
`timescale 1ns / 1ps

// Checks an ASCII date yyyy-mm-dd streamed one character per beat, the last
// character flagged by end_of_string, and returns one result per string:
// status (0 valid, 1 length not 10, 2 bad format, 3 impossible date) and, for
// a valid date, the weekday (0 Sunday .. 6 Saturday). A character is taken
// every cycle; the front only stalls when its two-entry result queue is full.
// A result passes from the edge that takes its last character through the queue
// write, two compute stages and the output register, and the back end retires
// one string per cycle, so strings of any length, even one character, flow at
// full rate as long as the output side keeps taking results.
module iso_date_check_and_weekday (
    input  logic                i_clk,
    input  logic                i_rst_n,
    iso_dc_in_if.sink           i_in,
    iso_dc_out_if.source        o_out
);

    logic                  accept;
    logic                  push;
    iso_dc_pkg::t_date_rec push_rec;
    logic                  q_full;
    logic                  q_valid;
    iso_dc_pkg::t_date_rec q_rec;
    logic                  pop;

    assign i_in.ready = !q_full;
    assign accept     = i_in.valid && !q_full;

    iso_dc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_char_code     (i_in.char_code),
        .i_end_of_string (i_in.end_of_string),
        .o_push          (push),
        .o_rec           (push_rec)
    );

    iso_dc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_rec),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_rec)
    );

    iso_dc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_rec     (q_rec),
        .o_pop     (pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_status  (o_out.status),
        .o_weekday (o_out.weekday)
    );

endmodule

// ===== src/iso_dc_chk.sv =====
`timescale 1ns / 1ps
`include "iso_date_check_and_weekday_defines.svh"

module iso_dc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_status,
    input logic [2:0] i_out_weekday
);

    `ISO_DC_ASSERT(a_weekday_zero_when_invalid, i_clk, i_rst_n, i_out_valid && i_out_status != iso_dc_pkg::ST_VALID |-> i_out_weekday == 3'd0, "weekday set on an invalid date")
    `ISO_DC_ASSERT(a_weekday_range, i_clk, i_rst_n, i_out_valid |-> i_out_weekday <= 3'd6, "weekday out of range")
    `ISO_DC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status) && $stable(i_out_weekday), "stalled result changed")
    `ISO_DC_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !i_out_valid, "result shown right after reset")

endmodule

bind iso_date_check_and_weekday iso_dc_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_weekday (o_out.weekday)
);
